// File: sv/gaps_pkg.sv
package gaps_pkg;

    localparam int SIDE  = 64;
    localparam int CRDW  = $clog2(SIDE);
    localparam int NCELL = SIDE * SIDE;
    localparam int IDXW  = $clog2(NCELL);
    localparam int CNTW  = IDXW + 1;
    localparam int ESTW  = 11;
    localparam int COSTW = 16;

    localparam logic [4:0] STEP_COST = 5'd10;
    localparam logic [4:0] DIAG_COST = 5'd14;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOPATH  = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DIAG   = 2'd2;
    localparam logic [1:0] REG_HMODE  = 2'd3;

    localparam logic [1:0] HM_EUCLID = 2'd1;
    localparam logic [1:0] HM_OCTAL  = 2'd2;

    localparam logic [1:0] STEP_DX [8] = '{2'b00, 2'b01, 2'b00, 2'b11,
                                           2'b11, 2'b01, 2'b11, 2'b01};
    localparam logic [1:0] STEP_DY [8] = '{2'b01, 2'b00, 2'b11, 2'b00,
                                           2'b11, 2'b01, 2'b01, 2'b11};

    localparam logic [4:0] ACT_NONE  = 5'd0;
    localparam logic [4:0] ACT_FCLR  = 5'd1;
    localparam logic [4:0] ACT_PBO   = 5'd2;
    localparam logic [4:0] ACT_CHKA  = 5'd3;
    localparam logic [4:0] ACT_CHKB  = 5'd4;
    localparam logic [4:0] ACT_CHKC  = 5'd5;
    localparam logic [4:0] ACT_NCLR  = 5'd6;
    localparam logic [4:0] ACT_SEST  = 5'd7;
    localparam logic [4:0] ACT_SRCW  = 5'd8;
    localparam logic [4:0] ACT_SCANI = 5'd9;
    localparam logic [4:0] ACT_SCAN  = 5'd10;
    localparam logic [4:0] ACT_PICK  = 5'd11;
    localparam logic [4:0] ACT_NBA   = 5'd12;
    localparam logic [4:0] ACT_NBR   = 5'd13;
    localparam logic [4:0] ACT_NBD   = 5'd14;
    localparam logic [4:0] ACT_NBW   = 5'd15;
    localparam logic [4:0] ACT_NXT   = 5'd16;
    localparam logic [4:0] ACT_TBR   = 5'd17;
    localparam logic [4:0] ACT_TBW   = 5'd18;
    localparam logic [4:0] ACT_EMIT  = 5'd19;

    typedef struct packed {
        logic              closed;
        logic              open;
        logic [COSTW-1:0]  cost;
        logic [ESTW-1:0]   est;
        logic [2:0]        pdir;
    } node_t;

    typedef struct packed {
        logic       take;
        logic [4:0] act;
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_op;
        logic       in_rd_ok;
        logic       out_free;
        logic       fclr_last;
        logic       ncl_last;
        logic       ep_ok;
        logic       est_done;
        logic       scan_done;
        logic       any;
        logic       is_target;
        logic       nb_in;
        logic       nb_new;
        logic       last_dir;
        logic       tb_end;
    } stat_t;

endpackage

// File: sv/grid_astar_path_search_top.sv
// Grid writes, op 3 and out-of-range path reads give their result in the cycle after
// the beat and run at one beat per cycle while results are taken. An in-range path
// read reads the path memory in S_PBW and gives its result from S_PBO. A search checks
// the endpoints, clears the node memory, then per expanded cell scans the open set over
// the node memory and visits up to 8 neighbors, then traces the path back. After reset
// the grid memory is cleared and no beat is taken; configuration writes are always taken.
module grid_astar_path_search_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op, cell_x, cell_y, cell_free, source_x, source_y, target_x, target_y, path_index
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, path_length, path_cost, step_x, step_y
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata
);
    import gaps_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    gaps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    gaps_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    assign s_tready = cmd.take;

endmodule

// File: sv/gaps_ram.sv
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/gaps_est.sv
module gaps_est (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [gaps_pkg::CRDW-1:0] x,
    input  logic [gaps_pkg::CRDW-1:0] y,
    input  logic [gaps_pkg::CRDW-1:0] tx,
    input  logic [gaps_pkg::CRDW-1:0] ty,
    input  logic [1:0]                mode,
    output logic                      done,
    output logic [gaps_pkg::ESTW-1:0] value
);
    import gaps_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SQ   = 3'd1;
    localparam logic [2:0] PH_MUL  = 3'd2;
    localparam logic [2:0] PH_IT   = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [2:0]      ph_reg, ph_next;
    logic [CRDW-1:0] dx_reg, dy_reg;
    logic [12:0]     sq_reg;
    logic [19:0]     n_reg;
    logic [9:0]      root_reg;
    logic [3:0]      bit_reg;
    logic [9:0]      trial;
    logic [19:0]     trial_sq;
    logic [CRDW:0]   dsum;
    logic [CRDW-1:0] lo;
    logic [ESTW-1:0] man;

    assign trial    = root_reg | (10'd1 << bit_reg);
    assign trial_sq = 20'(trial) * 20'(trial);
    assign dsum     = {1'b0, dx_reg} + {1'b0, dy_reg};
    assign lo       = (dx_reg < dy_reg) ? dx_reg : dy_reg;
    assign man      = ESTW'(dsum) * ESTW'(10);
    assign done     = (ph_reg == PH_DONE);

    always_comb begin
        if (mode == HM_EUCLID) begin
            value = {1'b0, root_reg};
        end else if (mode == HM_OCTAL) begin
            value = man - ESTW'(lo) * ESTW'(6);
        end else begin
            value = man;
        end
    end

    always_comb begin
        ph_next = ph_reg;
        unique case (ph_reg)
            PH_IDLE: ph_next = start ? PH_SQ : PH_IDLE;
            PH_SQ:   ph_next = PH_MUL;
            PH_MUL:  ph_next = PH_IT;
            PH_IT:   ph_next = (bit_reg == 4'd0) ? PH_DONE : PH_IT;
            PH_DONE: ph_next = PH_IDLE;
            default: ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_IDLE;
        end else begin
            ph_reg <= ph_next;
        end
        if (start) begin
            dx_reg <= (x > tx) ? x - tx : tx - x;
            dy_reg <= (y > ty) ? y - ty : ty - y;
        end
        if (ph_reg == PH_SQ) begin
            sq_reg <= 13'(dx_reg) * 13'(dx_reg) + 13'(dy_reg) * 13'(dy_reg);
        end
        if (ph_reg == PH_MUL) begin
            n_reg    <= 20'(sq_reg) * 20'd100;
            root_reg <= '0;
            bit_reg  <= 4'd9;
        end
        if (ph_reg == PH_IT) begin
            if (trial_sq <= n_reg) begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg - 4'd1;
        end
    end

endmodule

// File: sv/gaps_dp.sv
module gaps_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  gaps_pkg::cmd_t      cmd,
    output gaps_pkg::stat_t     stat,
    input  logic                s_tvalid,
    input  logic [55:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [6:0]          cfg_wdata
);
    import gaps_pkg::*;

    logic [6:0]       gw_reg, gh_reg, w_eff, h_eff;
    logic             diag_reg;
    logic [1:0]       hmode_reg;
    logic [CRDW-1:0]  sx_reg, sy_reg, tx_reg, ty_reg;
    logic [IDXW-1:0]  idx_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             rdv_reg;
    logic             any_reg;
    logic [16:0]      best_sc_reg;
    logic [IDXW-1:0]  best_idx_reg;
    node_t            best_reg;
    logic [CRDW-1:0]  cx_reg, cy_reg, nx_reg, ny_reg;
    logic [2:0]       dir_reg;
    logic             nin_reg;
    logic [COSTW-1:0] tc_reg;
    logic [IDXW-1:0]  cur_reg;
    logic [CNTW-1:0]  k_reg;
    logic [CNTW-1:0]  found_len_reg;
    logic [COSTW-1:0] found_cost_reg;
    logic [1:0]       pend_reg;
    logic             free_s_reg;
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [CNTW-1:0]  m_len_reg;
    logic [COSTW-1:0] m_cost_reg;
    logic [CRDW-1:0]  m_sx_reg, m_sy_reg;

    logic             accept;
    logic [1:0]       in_op;
    logic [IDXW-1:0]  s_idx, t_idx, n_idx;
    logic             free_we, free_wdata, free_rdata;
    logic [IDXW-1:0]  free_waddr, free_raddr;
    logic             node_we;
    logic [IDXW-1:0]  node_waddr, node_raddr;
    node_t            node_wdata, node_rdata;
    logic             pb_we;
    logic [IDXW-1:0]  pb_rdata;
    logic             est_start, est_done;
    logic [CRDW-1:0]  est_x, est_y;
    logic [ESTW-1:0]  est_val;
    logic [16:0]      sc;
    logic [7:0]       nx8, ny8, px8, py8;
    logic [16:0]      tc_sum;
    logic             nb_upd, nb_new;
    logic             prev_out, tb_end;
    logic             out_load;
    logic [1:0]       out_st;
    logic [CRDW-1:0]  out_sx, out_sy;

    assign w_eff  = (gw_reg > 7'(SIDE)) ? 7'(SIDE) : gw_reg;
    assign h_eff  = (gh_reg > 7'(SIDE)) ? 7'(SIDE) : gh_reg;
    assign accept = cmd.take && s_tvalid;
    assign in_op  = s_tdata[1:0];
    assign s_idx  = {sy_reg, sx_reg};
    assign t_idx  = {ty_reg, tx_reg};
    assign n_idx  = {ny_reg, nx_reg};

    assign sc = {1'b0, node_rdata.cost} + 17'(node_rdata.est);

    assign nx8 = {2'b00, cx_reg} + {{6{STEP_DX[dir_reg][1]}}, STEP_DX[dir_reg]};
    assign ny8 = {2'b00, cy_reg} + {{6{STEP_DY[dir_reg][1]}}, STEP_DY[dir_reg]};
    assign tc_sum = {1'b0, best_reg.cost}
                  + 17'(dir_reg[2] ? DIAG_COST : STEP_COST);

    assign px8 = {2'b00, cur_reg[CRDW-1:0]}
               - {{6{STEP_DX[node_rdata.pdir][1]}}, STEP_DX[node_rdata.pdir]};
    assign py8 = {2'b00, cur_reg[IDXW-1:CRDW]}
               - {{6{STEP_DY[node_rdata.pdir][1]}}, STEP_DY[node_rdata.pdir]};
    assign prev_out = (px8 >= 8'(SIDE)) || (py8 >= 8'(SIDE));
    assign tb_end   = (cur_reg == s_idx) || prev_out || (k_reg == CNTW'(NCELL - 1));

    assign nb_new = free_rdata && !node_rdata.closed && !node_rdata.open;
    assign nb_upd = free_rdata && !node_rdata.closed && node_rdata.open
                  && (tc_reg < node_rdata.cost);

    assign est_start = (cmd.act == ACT_SEST) || ((cmd.act == ACT_NBD) && nb_new);
    assign est_x     = (cmd.act == ACT_SEST) ? sx_reg : nx_reg;
    assign est_y     = (cmd.act == ACT_SEST) ? sy_reg : ny_reg;

    always_comb begin
        stat           = '0;
        stat.in_valid  = s_tvalid;
        stat.in_op     = in_op;
        stat.in_rd_ok  = {1'b0, s_tdata[50:39]} < found_len_reg;
        stat.out_free  = !m_valid_reg || m_tready;
        stat.fclr_last = (cnt_reg[IDXW-1:0] == IDXW'(NCELL - 1));
        stat.ncl_last  = (cnt_reg[IDXW-1:0] == IDXW'(NCELL - 1));
        stat.ep_ok     = ({1'b0, sx_reg} < w_eff) && ({1'b0, sy_reg} < h_eff)
                       && ({1'b0, tx_reg} < w_eff) && ({1'b0, ty_reg} < h_eff)
                       && free_s_reg && free_rdata;
        stat.est_done  = est_done;
        stat.scan_done = cnt_reg[IDXW] && !rdv_reg;
        stat.any       = any_reg;
        stat.is_target = (best_idx_reg == t_idx);
        stat.nb_in     = nin_reg;
        stat.nb_new    = nb_new;
        stat.last_dir  = (dir_reg == (diag_reg ? 3'd7 : 3'd3));
        stat.tb_end    = tb_end;
    end

    always_comb begin
        free_we    = 1'b0;
        free_waddr = cnt_reg[IDXW-1:0];
        free_wdata = 1'b0;
        if (cmd.act == ACT_FCLR) begin
            free_we = 1'b1;
        end else if (accept && (in_op == OP_WRITE)) begin
            free_we    = 1'b1;
            free_waddr = {s_tdata[13:8], s_tdata[7:2]};
            free_wdata = s_tdata[14];
        end
    end

    always_comb begin
        unique case (cmd.act)
            ACT_CHKA: free_raddr = s_idx;
            ACT_CHKB: free_raddr = t_idx;
            default:  free_raddr = n_idx;
        endcase
    end

    always_comb begin
        unique case (cmd.act)
            ACT_NBR: node_raddr = n_idx;
            ACT_TBR: node_raddr = cur_reg;
            default: node_raddr = cnt_reg[IDXW-1:0];
        endcase
    end

    always_comb begin
        node_we    = 1'b0;
        node_waddr = n_idx;
        node_wdata = '0;
        unique case (cmd.act)
            ACT_NCLR: begin
                node_we    = 1'b1;
                node_waddr = cnt_reg[IDXW-1:0];
            end
            ACT_SRCW: begin
                node_we         = 1'b1;
                node_waddr      = s_idx;
                node_wdata.open = 1'b1;
                node_wdata.est  = est_val;
            end
            ACT_PICK: begin
                node_we           = any_reg && (best_idx_reg != t_idx);
                node_waddr        = best_idx_reg;
                node_wdata        = best_reg;
                node_wdata.open   = 1'b0;
                node_wdata.closed = 1'b1;
            end
            ACT_NBD: begin
                node_we         = nb_upd;
                node_wdata      = node_rdata;
                node_wdata.cost = tc_reg;
                node_wdata.pdir = dir_reg;
            end
            ACT_NBW: begin
                node_we         = 1'b1;
                node_wdata.open = 1'b1;
                node_wdata.cost = tc_reg;
                node_wdata.est  = est_val;
                node_wdata.pdir = dir_reg;
            end
            default: node_we = 1'b0;
        endcase
    end

    assign pb_we = (cmd.act == ACT_TBW);

    always_comb begin
        out_load = 1'b0;
        out_st   = ST_OK;
        out_sx   = '0;
        out_sy   = '0;
        if (accept) begin
            if (in_op == OP_READ) begin
                out_load = !stat.in_rd_ok;
                out_st   = ST_RANGE;
            end else begin
                out_load = (in_op != OP_SEARCH);
            end
        end else if (cmd.act == ACT_PBO) begin
            out_load = 1'b1;
            out_sx   = pb_rdata[CRDW-1:0];
            out_sy   = pb_rdata[IDXW-1:CRDW];
        end else if (cmd.act == ACT_EMIT) begin
            out_load = 1'b1;
            out_st   = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg         <= 7'(SIDE);
            gh_reg         <= 7'(SIDE);
            diag_reg       <= 1'b1;
            hmode_reg      <= HM_EUCLID;
            found_len_reg  <= '0;
            found_cost_reg <= '0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
            rdv_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_WIDTH:  gw_reg    <= cfg_wdata;
                    REG_HEIGHT: gh_reg    <= cfg_wdata;
                    REG_DIAG:   diag_reg  <= cfg_wdata[0];
                    REG_HMODE:  hmode_reg <= cfg_wdata[1:0];
                    default:    gw_reg    <= gw_reg;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept && (in_op == OP_SEARCH)) begin
                found_len_reg  <= '0;
                found_cost_reg <= '0;
            end
            unique case (cmd.act)
                ACT_FCLR, ACT_NCLR: cnt_reg <= cnt_reg + CNTW'(1);
                ACT_CHKC: cnt_reg <= '0;
                ACT_SCANI: begin
                    cnt_reg <= '0;
                    rdv_reg <= 1'b0;
                end
                ACT_SCAN: begin
                    rdv_reg <= !cnt_reg[IDXW];
                    if (!cnt_reg[IDXW]) begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                end
                ACT_PICK: begin
                    if (any_reg && (best_idx_reg == t_idx)) begin
                        found_cost_reg <= best_reg.cost;
                    end
                end
                ACT_TBW: begin
                    if (tb_end) begin
                        found_len_reg <= k_reg + CNTW'(1);
                    end
                end
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= out_st;
            m_len_reg    <= found_len_reg;
            m_cost_reg   <= found_cost_reg;
            m_sx_reg     <= out_sx;
            m_sy_reg     <= out_sy;
        end
        if (accept) begin
            sx_reg  <= s_tdata[20:15];
            sy_reg  <= s_tdata[26:21];
            tx_reg  <= s_tdata[32:27];
            ty_reg  <= s_tdata[38:33];
            idx_reg <= s_tdata[50:39];
        end
        unique case (cmd.act)
            ACT_CHKB: free_s_reg <= free_rdata;
            ACT_CHKC: pend_reg <= ST_BLOCKED;
            ACT_SCANI: any_reg <= 1'b0;
            ACT_SCAN: begin
                if (rdv_reg && node_rdata.open && (!any_reg || (sc < best_sc_reg))) begin
                    any_reg      <= 1'b1;
                    best_sc_reg  <= sc;
                    best_idx_reg <= cnt_reg[IDXW-1:0] - IDXW'(1);
                    best_reg     <= node_rdata;
                end
            end
            ACT_PICK: begin
                cx_reg  <= best_idx_reg[CRDW-1:0];
                cy_reg  <= best_idx_reg[IDXW-1:CRDW];
                dir_reg <= '0;
                cur_reg <= best_idx_reg;
                k_reg   <= '0;
                pend_reg <= ST_NOPATH;
            end
            ACT_NBA: begin
                nx_reg  <= nx8[CRDW-1:0];
                ny_reg  <= ny8[CRDW-1:0];
                nin_reg <= !nx8[7] && !ny8[7] && (nx8[6:0] < w_eff) && (ny8[6:0] < h_eff);
                tc_reg  <= tc_sum[16] ? {COSTW{1'b1}} : tc_sum[COSTW-1:0];
            end
            ACT_NXT: dir_reg <= dir_reg + 3'd1;
            ACT_TBW: begin
                if (tb_end) begin
                    pend_reg <= ST_OK;
                end else begin
                    cur_reg <= {py8[CRDW-1:0], px8[CRDW-1:0]};
                    k_reg   <= k_reg + CNTW'(1);
                end
            end
            default: free_s_reg <= free_s_reg;
        endcase
    end

    gaps_ram #(.WIDTH(1), .DEPTH(NCELL)) u_free (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    gaps_ram #(.WIDTH($bits(node_t)), .DEPTH(NCELL)) u_node (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    gaps_ram #(.WIDTH(IDXW), .DEPTH(NCELL)) u_path (
        .aclk  (aclk),
        .we    (pb_we),
        .waddr (k_reg[IDXW-1:0]),
        .wdata (cur_reg),
        .raddr (idx_reg),
        .rdata (pb_rdata)
    );

    gaps_est u_est (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (est_start),
        .x       (est_x),
        .y       (est_y),
        .tx      (tx_reg),
        .ty      (ty_reg),
        .mode    (hmode_reg),
        .done    (est_done),
        .value   (est_val)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_sy_reg, m_sx_reg, m_cost_reg, m_len_reg, m_status_reg};

endmodule

// File: sv/gaps_ctrl.sv
module gaps_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  gaps_pkg::stat_t stat,
    output gaps_pkg::cmd_t  cmd
);
    import gaps_pkg::*;

    localparam logic [4:0] S_FCLR  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_PBW   = 5'd2;
    localparam logic [4:0] S_PBO   = 5'd3;
    localparam logic [4:0] S_CHKA  = 5'd4;
    localparam logic [4:0] S_CHKB  = 5'd5;
    localparam logic [4:0] S_CHKC  = 5'd6;
    localparam logic [4:0] S_NCLR  = 5'd7;
    localparam logic [4:0] S_SEST  = 5'd8;
    localparam logic [4:0] S_SESTW = 5'd9;
    localparam logic [4:0] S_SCANI = 5'd10;
    localparam logic [4:0] S_SCAN  = 5'd11;
    localparam logic [4:0] S_PICK  = 5'd12;
    localparam logic [4:0] S_NBA   = 5'd13;
    localparam logic [4:0] S_NBR   = 5'd14;
    localparam logic [4:0] S_NBD   = 5'd15;
    localparam logic [4:0] S_NBE   = 5'd16;
    localparam logic [4:0] S_NXT   = 5'd17;
    localparam logic [4:0] S_TBR   = 5'd18;
    localparam logic [4:0] S_TBW   = 5'd19;
    localparam logic [4:0] S_EMIT  = 5'd20;

    logic [4:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_FCLR: begin
                cmd.act = ACT_FCLR;
                if (stat.fclr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                cmd.take = stat.out_free;
                if (stat.out_free && stat.in_valid) begin
                    if (stat.in_op == OP_SEARCH) begin
                        state_next = S_CHKA;
                    end else if ((stat.in_op == OP_READ) && stat.in_rd_ok) begin
                        state_next = S_PBW;
                    end
                end
            end
            S_PBW: state_next = S_PBO;
            S_PBO: begin
                if (stat.out_free) begin
                    cmd.act    = ACT_PBO;
                    state_next = S_IDLE;
                end
            end
            S_CHKA: begin
                cmd.act    = ACT_CHKA;
                state_next = S_CHKB;
            end
            S_CHKB: begin
                cmd.act    = ACT_CHKB;
                state_next = S_CHKC;
            end
            S_CHKC: begin
                cmd.act    = ACT_CHKC;
                state_next = stat.ep_ok ? S_NCLR : S_EMIT;
            end
            S_NCLR: begin
                cmd.act = ACT_NCLR;
                if (stat.ncl_last) state_next = S_SEST;
            end
            S_SEST: begin
                cmd.act    = ACT_SEST;
                state_next = S_SESTW;
            end
            S_SESTW: begin
                if (stat.est_done) begin
                    cmd.act    = ACT_SRCW;
                    state_next = S_SCANI;
                end
            end
            S_SCANI: begin
                cmd.act    = ACT_SCANI;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.act = ACT_SCAN;
                if (stat.scan_done) state_next = S_PICK;
            end
            S_PICK: begin
                cmd.act = ACT_PICK;
                priority if (!stat.any) begin
                    state_next = S_EMIT;
                end else if (stat.is_target) begin
                    state_next = S_TBR;
                end else begin
                    state_next = S_NBA;
                end
            end
            S_NBA: begin
                cmd.act    = ACT_NBA;
                state_next = S_NBR;
            end
            S_NBR: begin
                if (stat.nb_in) begin
                    cmd.act    = ACT_NBR;
                    state_next = S_NBD;
                end else begin
                    state_next = S_NXT;
                end
            end
            S_NBD: begin
                cmd.act    = ACT_NBD;
                state_next = stat.nb_new ? S_NBE : S_NXT;
            end
            S_NBE: begin
                if (stat.est_done) begin
                    cmd.act    = ACT_NBW;
                    state_next = S_NXT;
                end
            end
            S_NXT: begin
                cmd.act    = ACT_NXT;
                state_next = stat.last_dir ? S_SCANI : S_NBA;
            end
            S_TBR: begin
                cmd.act    = ACT_TBR;
                state_next = S_TBW;
            end
            S_TBW: begin
                cmd.act    = ACT_TBW;
                state_next = stat.tb_end ? S_EMIT : S_TBR;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.act    = ACT_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_FCLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/gaps_checker.sv
module gaps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == 2'd3) |-> (m_tdata[42:31] == 12'd0))
        else $error("out-of-range read returned a cell");

    a_empty_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[14:2] == 13'd0) |-> (m_tdata[30:15] == 16'd0))
        else $error("empty path with nonzero cost");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind grid_astar_path_search_top gaps_checker u_checker (.*);

// File: sim/grid_astar_path_search_checker.sv
`timescale 1ns / 100ps

module grid_astar_path_search_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import gaps_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [12:0] path_length;
        logic [15:0] path_cost;
        logic [5:0]  step_x;
        logic [5:0]  step_y;
    } answer_t;

    localparam int MOVE_DX [8] = '{0, 1, 0, -1, -1, 1, -1, 1};
    localparam int MOVE_DY [8] = '{1, 0, -1, 0, -1, 1, 1, -1};

    answer_t answers[$];

    bit free_cell [NCELL];
    bit in_open [NCELL];
    bit in_closed [NCELL];
    int g_cost [NCELL];
    int h_est [NCELL];
    int came_dir [NCELL];
    int route [NCELL];
    int route_len;
    int route_cost;
    int cols_reg;
    int rows_reg;
    int diag_reg;
    int hmode_reg;

    function automatic int sqrt_floor(int unsigned n);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= n) r++;
        return r;
    endfunction

    function automatic int distance_guess(int x, int y, int tx, int ty);
        int dx;
        int dy;
        int lo;
        dx = (x > tx) ? x - tx : tx - x;
        dy = (y > ty) ? y - ty : ty - y;
        lo = (dx < dy) ? dx : dy;
        if (hmode_reg == HM_EUCLID) return sqrt_floor(100 * (dx * dx + dy * dy));
        if (hmode_reg == HM_OCTAL) return 10 * (dx + dy) - 6 * lo;
        return 10 * (dx + dy);
    endfunction

    function automatic bit is_wall(int x, int y, int w, int h);
        if (x < 0 || y < 0 || x >= w || y >= h) return 1'b1;
        return !free_cell[y * SIDE + x];
    endfunction

    function automatic logic [1:0] find_route(int sx, int sy, int tx, int ty);
        int w;
        int h;
        int ndir;
        int src;
        int dst;
        int cur;
        int best;
        int sc;
        int nx;
        int ny;
        int n;
        int tc;
        int k;
        int cx;
        int cy;
        bit any;
        bit found;
        w = (cols_reg > SIDE) ? SIDE : cols_reg;
        h = (rows_reg > SIDE) ? SIDE : rows_reg;
        ndir = diag_reg ? 8 : 4;
        route_len = 0;
        route_cost = 0;
        found = 1'b0;
        cur = 0;
        if (is_wall(sx, sy, w, h) || is_wall(tx, ty, w, h)) return ST_BLOCKED;
        foreach (in_open[i]) begin
            in_open[i] = 1'b0;
            in_closed[i] = 1'b0;
        end
        src = sy * SIDE + sx;
        dst = ty * SIDE + tx;
        in_open[src] = 1'b1;
        g_cost[src] = 0;
        h_est[src] = distance_guess(sx, sy, tx, ty);
        came_dir[src] = 0;
        forever begin
            any = 1'b0;
            best = 0;
            for (int i = 0; i < NCELL; i++) begin
                if (in_open[i]) begin
                    sc = g_cost[i] + h_est[i];
                    if (!any || sc < best) begin
                        any = 1'b1;
                        best = sc;
                        cur = i;
                    end
                end
            end
            if (!any) break;
            if (cur == dst) begin
                found = 1'b1;
                break;
            end
            in_open[cur] = 1'b0;
            in_closed[cur] = 1'b1;
            cx = cur % SIDE;
            cy = cur / SIDE;
            for (int d = 0; d < ndir; d++) begin
                nx = cx + MOVE_DX[d];
                ny = cy + MOVE_DY[d];
                if (is_wall(nx, ny, w, h)) continue;
                n = ny * SIDE + nx;
                if (in_closed[n]) continue;
                tc = g_cost[cur] + ((d < 4) ? 10 : 14);
                if (tc > 65535) tc = 65535;
                if (!in_open[n]) begin
                    in_open[n] = 1'b1;
                    g_cost[n] = tc;
                    h_est[n] = distance_guess(nx, ny, tx, ty);
                    came_dir[n] = d;
                end else if (tc < g_cost[n]) begin
                    g_cost[n] = tc;
                    came_dir[n] = d;
                end
            end
        end
        if (!found) return ST_NOPATH;
        route_cost = g_cost[dst];
        k = 0;
        cur = dst;
        while (k < NCELL) begin
            cx = cur % SIDE;
            cy = cur / SIDE;
            route[k] = cur;
            k++;
            if (cur == src) break;
            cx -= MOVE_DX[came_dir[cur]];
            cy -= MOVE_DY[came_dir[cur]];
            if (cx < 0 || cy < 0 || cx >= SIDE || cy >= SIDE) break;
            cur = cy * SIDE + cx;
        end
        route_len = k;
        return ST_OK;
    endfunction

    function automatic answer_t predict_answer(logic [55:0] beat);
        answer_t a;
        logic [1:0] op;
        int idx;
        op = beat[1:0];
        a.status = ST_OK;
        a.step_x = '0;
        a.step_y = '0;
        if (op == OP_WRITE) begin
            free_cell[beat[13:8] * SIDE + beat[7:2]] = beat[14];
        end else if (op == OP_SEARCH) begin
            a.status = find_route(beat[20:15], beat[26:21], beat[32:27], beat[38:33]);
        end else if (op == OP_READ) begin
            idx = beat[50:39];
            if (idx < route_len) begin
                a.step_x = 6'(route[idx] % SIDE);
                a.step_y = 6'(route[idx] / SIDE);
            end else begin
                a.status = ST_RANGE;
            end
        end
        a.path_length = 13'(route_len);
        a.path_cost = 16'(route_cost);
        return a;
    endfunction

    always @(posedge aclk) begin
        answer_t exp_a;
        if (!aresetn) begin
            foreach (free_cell[i]) free_cell[i] = 1'b0;
            route_len = 0;
            route_cost = 0;
            cols_reg = 64;
            rows_reg = 64;
            diag_reg = 1;
            hmode_reg = 1;
            answers.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_WIDTH: cols_reg = cfg_wdata;
                    REG_HEIGHT: rows_reg = cfg_wdata;
                    REG_DIAG: diag_reg = cfg_wdata[0];
                    REG_HMODE: hmode_reg = cfg_wdata[1:0];
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (answers.size() == 0) begin
                    $error("result beat with no expectation: %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_a = answers.pop_front();
                    if (m_tdata[1:0] !== exp_a.status) begin
                        $error("status: expected %0d, got %0d", exp_a.status, m_tdata[1:0]);
                        fail_count++;
                    end
                    if (m_tdata[14:2] !== exp_a.path_length) begin
                        $error("path_length: expected %0d, got %0d",
                               exp_a.path_length, m_tdata[14:2]);
                        fail_count++;
                    end
                    if (m_tdata[30:15] !== exp_a.path_cost) begin
                        $error("path_cost: expected %0d, got %0d",
                               exp_a.path_cost, m_tdata[30:15]);
                        fail_count++;
                    end
                    if (m_tdata[36:31] !== exp_a.step_x) begin
                        $error("step_x: expected %0d, got %0d", exp_a.step_x, m_tdata[36:31]);
                        fail_count++;
                    end
                    if (m_tdata[42:37] !== exp_a.step_y) begin
                        $error("step_y: expected %0d, got %0d", exp_a.step_y, m_tdata[42:37]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) answers.insert(answers.size(), predict_answer(s_tdata));
        end
        pending = answers.size();
    end

endmodule

// File: sim/grid_astar_path_search_top_tb.sv
`timescale 1ns / 100ps

module grid_astar_path_search_top_tb;
    import gaps_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [6:0]  cfg_wdata;
    int          fail_count;
    int          pending;
    bit          quiet;
    int          stall_left;

    grid_astar_path_search_top dut (.*);

    grid_astar_path_search_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #1_000_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
            m_tready <= 1'b1;
        end else if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 4);
            m_tready <= 1'b0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(logic [1:0] op, int cx, int cy, int cf, int sx, int sy,
                             int tx, int ty, int pidx);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, 12'(pidx), 6'(ty), 6'(tx), 6'(sy), 6'(sx), 1'(cf), 6'(cy), 6'(cx), op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_cell(int x, int y, int f);
        send_beat(OP_WRITE, x, y, f, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic search_route(int sx, int sy, int tx, int ty);
        send_beat(OP_SEARCH, $urandom, $urandom, $urandom, sx, sy, tx, ty, $urandom);
    endtask

    task automatic read_step(int idx);
        send_beat(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, idx);
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic set_grid(int w, int h, int dg, int hm);
        drain_results();
        cfg_we <= 1'b1;
        cfg_addr <= REG_WIDTH;
        cfg_wdata <= 7'(w);
        @(posedge aclk);
        cfg_addr <= REG_HEIGHT;
        cfg_wdata <= 7'(h);
        @(posedge aclk);
        cfg_addr <= REG_DIAG;
        cfg_wdata <= 7'(dg);
        @(posedge aclk);
        cfg_addr <= REG_HMODE;
        cfg_wdata <= 7'(hm);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic int near_coord();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 63);
        return $urandom_range(0, 3);
    endfunction

    task automatic random_beat();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            write_cell(near_coord(), near_coord(), $urandom_range(0, 9) < 7);
        end else if (pick < 55) begin
            search_route(near_coord(), near_coord(), near_coord(), near_coord());
        end else if (pick < 96) begin
            read_step(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 7));
        end else begin
            send_beat(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        end
    endtask

    initial begin
        int w;
        int h;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        quiet = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        read_step(0);
        write_cell(0, 0, 1);
        write_cell(1, 0, 1);
        write_cell(2, 0, 1);
        write_cell(0, 1, 1);
        write_cell(1, 1, 1);
        write_cell(2, 2, 1);
        write_cell(63, 63, 1);
        search_route(0, 0, 2, 2);
        read_step(0);
        read_step(1);
        read_step(2);
        read_step(4095);
        search_route(0, 0, 0, 0);
        read_step(0);
        search_route(0, 0, 5, 5);
        read_step(0);
        search_route(0, 0, 63, 63);
        send_beat(OP_NOP, 63, 63, 1, 63, 63, 63, 63, 4095);
        write_cell(63, 63, 0);
        drain_results();
        search_route(2, 2, 0, 1);

        set_grid(0, 3, 0, 0);
        search_route(0, 0, 1, 0);
        set_grid(127, 127, 1, 2);
        search_route(2, 2, 0, 0);
        read_step(1);
        set_grid(1, 1, 0, 3);
        search_route(0, 0, 0, 0);
        set_grid(3, 2, 0, 0);
        search_route(0, 0, 2, 0);
        read_step(2);

        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 2) begin
                w = 64;
                h = 64;
            end else begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 5);
                h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 5);
            end
            set_grid(w, h, $urandom_range(0, 1), $urandom_range(0, 3));
            if (ph == 9) quiet = 1'b1;
            for (int i = 0; i < 50; i++) begin
                random_beat();
                if (ph == 4 && i == 25) drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
sv/gaps_pkg.sv
sv/gaps_ram.sv
sv/gaps_est.sv
sv/gaps_dp.sv
sv/gaps_ctrl.sv
sv/grid_astar_path_search_top.sv
sv/gaps_checker.sv
sim/grid_astar_path_search_checker.sv
sim/grid_astar_path_search_top_tb.sv
